// File: rtl/shss_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and reset values of the stepper homing and sector sequencer.
package shss_pkg;

	localparam int SECTORS_DEF       = 6;
	localparam int POSITION_BITS_DEF = 10;

	localparam int CFG_DATA_W  = 60;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_MOVE_HALF      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HOME_HALF      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_TIMEOUT  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SECOND_TIMEOUT = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE       = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE         = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_WAIT           = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_POSITIONS      = 3'd7;

	localparam logic [7:0]  MOVE_HALF_RST      = 8'd4;
	localparam logic [7:0]  HOME_HALF_RST      = 8'd7;
	localparam logic [11:0] FIRST_TIMEOUT_RST  = 12'd357;
	localparam logic [11:0] SECOND_TIMEOUT_RST = 12'd142;
	localparam logic [3:0]  DEBOUNCE_RST       = 4'd5;
	localparam logic [15:0] SETTLE_RST         = 16'd500;
	localparam logic [15:0] WAIT_RST           = 16'd5000;
	localparam logic [59:0] POSITIONS_RST      = 60'd214091540930309120;

	typedef enum logic [2:0] {
		PH_HOME1  = 3'd0,
		PH_SETTLE = 3'd1,
		PH_HOME2  = 3'd2,
		PH_WAIT1  = 3'd3,
		PH_MOVE   = 3'd4,
		PH_WAIT2  = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0]  move_half;
		logic [7:0]  home_half;
		logic [11:0] first_timeout;
		logic [11:0] second_timeout;
		logic [3:0]  debounce;
		logic [15:0] settle;
		logic [15:0] wait_len;
		logic [59:0] positions;
	} cfg_t;

	typedef struct packed {
		logic       step_level;
		logic       dir_level;
		logic       enable_n;
		logic [2:0] phase;
		logic [2:0] current_sector;
		logic       home_confirmed;
	} res_t;

endpackage

// File: rtl/shss_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the tick input and the pin result output.
interface shss_in_if;
	logic valid;
	logic ready;
	logic home_switch_level;

	modport source (output valid, output home_switch_level, input ready);
	modport sink (input valid, input home_switch_level, output ready);
endinterface

interface shss_out_if;
	logic       valid;
	logic       ready;
	logic       step_level;
	logic       dir_level;
	logic       enable_n;
	logic [2:0] phase;
	logic [2:0] current_sector;
	logic       home_confirmed;

	modport source (output valid, output step_level, output dir_level, output enable_n,
		output phase, output current_sector, output home_confirmed, input ready);
	modport sink (input valid, input step_level, input dir_level, input enable_n,
		input phase, input current_sector, input home_confirmed, output ready);
endinterface

// File: rtl/stepper_home_and_sector_sequencer.sv
`timescale 1ns / 1ps
// Top level of the stepper homing and sector sequencer.
//
// Each word on tick_in is one 1 ms tick carrying the raw active-low home
// switch level. For every tick the block returns one word on result_out with
// the STEP, DIR and ENABLE pin levels, the phase, the sector and a home
// confirmation flag, all showing the state after that tick.
// The block loops through homing pass one, settle, homing pass two, a wait,
// a forward move to the sector's position and a final wait, then advances
// the sector index.
// The result of a tick sits in the output register on the cycle after it is
// accepted. Throughput is one tick per cycle, set by the single next-state
// pass between the state registers and the output register. While the
// receiver stalls, the output register holds its word and a new tick is
// taken only as the held word leaves.
// Reset puts the sequencer in homing pass one with the motor disabled and the
// direction forward, loads the register defaults and empties the output.
// Write registers over wr_en/wr_index/wr_data only while idle; unenforced.
module stepper_home_and_sector_sequencer #(
	parameter int SECTORS       = shss_pkg::SECTORS_DEF,
	parameter int POSITION_BITS = shss_pkg::POSITION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	shss_in_if.sink                           tick_in,
	shss_out_if.source                        result_out,
	input  logic                              wr_en,
	input  logic [shss_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [shss_pkg::CFG_DATA_W-1:0]   wr_data
);
	import shss_pkg::*;

	cfg_t cfg;
	res_t res;
	res_t out_q;
	logic out_valid_q;
	logic take;

	assign tick_in.ready = !out_valid_q || result_out.ready;
	assign take          = tick_in.valid && tick_in.ready;

	shss_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	shss_core #(
		.SECTORS       (SECTORS),
		.POSITION_BITS (POSITION_BITS)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (take),
		.home_switch_level (tick_in.home_switch_level),
		.cfg               (cfg),
		.res               (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_q <= res;
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.step_level     = out_q.step_level;
	assign result_out.dir_level      = out_q.dir_level;
	assign result_out.enable_n       = out_q.enable_n;
	assign result_out.phase          = out_q.phase;
	assign result_out.current_sector = out_q.current_sector;
	assign result_out.home_confirmed = out_q.home_confirmed;

	// An accepted tick always leaves a word in the output register.
	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q)
		else $error("accepted tick produced no result word");

	// A confirmed home ends the pass, so the reported phase is the one after it.
	a_confirm_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.home_confirmed) |->
			(out_q.phase == PH_SETTLE || out_q.phase == PH_WAIT1))
		else $error("home confirmed outside the end of a homing pass");

	// The driver is energized during homing and moves.
	a_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_q.phase == PH_HOME1 || out_q.phase == PH_HOME2 ||
			out_q.phase == PH_MOVE)) |-> !out_q.enable_n)
		else $error("motor not enabled while stepping phase is active");

	// Moves run forward and homing runs backward while a step pulse is high.
	a_direction: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.step_level) |->
			(out_q.dir_level == (out_q.phase == PH_MOVE)))
		else $error("direction pin does not match phase");

	// The sector index stays inside the table.
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.current_sector <= 3'(SECTORS - 1)))
		else $error("sector index out of range");

endmodule

// File: rtl/shss_cfg.sv
`timescale 1ns / 1ps
// Configuration register file written through a plain write port.
module shss_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [shss_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  logic [shss_pkg::CFG_DATA_W-1:0]     wr_data,
	output shss_pkg::cfg_t                      cfg
);
	import shss_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_half      <= MOVE_HALF_RST;
			cfg_q.home_half      <= HOME_HALF_RST;
			cfg_q.first_timeout  <= FIRST_TIMEOUT_RST;
			cfg_q.second_timeout <= SECOND_TIMEOUT_RST;
			cfg_q.debounce       <= DEBOUNCE_RST;
			cfg_q.settle         <= SETTLE_RST;
			cfg_q.wait_len       <= WAIT_RST;
			cfg_q.positions      <= POSITIONS_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_MOVE_HALF:      cfg_q.move_half      <= wr_data[7:0];
				REG_HOME_HALF:      cfg_q.home_half      <= wr_data[7:0];
				REG_FIRST_TIMEOUT:  cfg_q.first_timeout  <= wr_data[11:0];
				REG_SECOND_TIMEOUT: cfg_q.second_timeout <= wr_data[11:0];
				REG_DEBOUNCE:       cfg_q.debounce       <= wr_data[3:0];
				REG_SETTLE:         cfg_q.settle         <= wr_data[15:0];
				REG_WAIT:           cfg_q.wait_len       <= wr_data[15:0];
				REG_POSITIONS:      cfg_q.positions      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/shss_core.sv
`timescale 1ns / 1ps
// Sequencer state registers and the single-pass next-state logic for one tick.
module shss_core #(
	parameter int SECTORS       = shss_pkg::SECTORS_DEF,
	parameter int POSITION_BITS = shss_pkg::POSITION_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           home_switch_level,
	input  shss_pkg::cfg_t cfg,
	output shss_pkg::res_t res
);
	import shss_pkg::*;

	localparam logic [2:0] LAST_SECTOR = 3'(SECTORS - 1);

	typedef struct packed {
		phase_t      phase;
		logic [15:0] tick;
		logic [11:0] steps;
		logic [3:0]  samples;
		logic [2:0]  sector;
		logic        step_pin;
		logic        dir;
		logic        en_n;
		logic        stepping;
	} st_t;

	st_t st_q;
	st_t st_d;
	logic confirmed;

	logic [7:0]              home_h;
	logic [7:0]              move_h;
	logic [POSITION_BITS-1:0] target;

	function automatic st_t enter(input st_t s, input phase_t p);
		st_t r;
		r          = s;
		r.phase    = p;
		r.tick     = '0;
		r.steps    = '0;
		r.samples  = '0;
		r.stepping = 1'b0;
		r.step_pin = 1'b0;
		return r;
	endfunction

	assign home_h = (cfg.home_half == 8'd0) ? 8'd1 : cfg.home_half;
	assign move_h = (cfg.move_half == 8'd0) ? 8'd1 : cfg.move_half;

	always_comb begin
		if (st_q.sector > LAST_SECTOR) begin
			target = '0;
		end else begin
			target = cfg.positions[POSITION_BITS*st_q.sector +: POSITION_BITS];
		end
	end

	always_comb begin
		logic        go;
		logic [7:0]  half;
		logic [11:0] timeout;
		logic [3:0]  smp;
		logic [15:0] t_inc;
		phase_t      next_ph;
		st_d      = st_q;
		confirmed = 1'b0;
		go        = 1'b0;
		smp       = st_q.samples + 4'd1;
		t_inc     = st_q.tick + 16'd1;
		half      = (st_q.phase == PH_MOVE) ? move_h : home_h;
		timeout   = (st_q.phase == PH_HOME1) ? cfg.first_timeout : cfg.second_timeout;
		next_ph   = (st_q.phase == PH_HOME1) ? PH_SETTLE : PH_WAIT1;

		// Shared pulse timing: a step is high for half ticks, then low for half ticks.
		if (st_q.stepping) begin
			if (st_q.tick != 16'd0) begin
				st_d.tick = st_q.tick - 16'd1;
			end else if (st_q.step_pin) begin
				st_d.step_pin = 1'b0;
				st_d.tick     = {8'd0, half - 8'd1};
			end else begin
				st_d.stepping = 1'b0;
				st_d.steps    = st_q.steps + 12'd1;
				go            = 1'b1;
			end
		end else if (st_q.tick != 16'd0 && st_q.phase != PH_MOVE) begin
			st_d.tick = st_q.tick - 16'd1;
		end else begin
			go = 1'b1;
		end

		case (st_q.phase)
			PH_HOME1, PH_HOME2: begin
				st_d.en_n = 1'b0;
				st_d.dir  = 1'b0;
				if (go) begin
					if (st_d.steps >= timeout) begin
						st_d = enter(st_d, next_ph);
					end else if (cfg.debounce == 4'd0) begin
						st_d      = enter(st_d, next_ph);
						confirmed = 1'b1;
					end else if (!home_switch_level) begin
						if (smp >= cfg.debounce) begin
							st_d      = enter(st_d, next_ph);
							confirmed = 1'b1;
						end else begin
							st_d.samples = smp;
							st_d.tick    = 16'd1;
						end
					end else begin
						st_d.samples  = '0;
						st_d.stepping = 1'b1;
						st_d.step_pin = 1'b1;
						st_d.tick     = {8'd0, half - 8'd1};
					end
				end
			end
			PH_SETTLE: begin
				st_d.tick = t_inc;
				if (t_inc >= cfg.settle) st_d = enter(st_d, PH_HOME2);
			end
			PH_WAIT1: begin
				st_d.tick = t_inc;
				if (t_inc >= cfg.wait_len) st_d = enter(st_d, PH_MOVE);
			end
			PH_MOVE: begin
				st_d.en_n = 1'b0;
				st_d.dir  = 1'b1;
				if (go) begin
					if (st_d.steps >= 12'(target)) begin
						st_d = enter(st_d, PH_WAIT2);
					end else begin
						st_d.stepping = 1'b1;
						st_d.step_pin = 1'b1;
						st_d.tick     = {8'd0, half - 8'd1};
					end
				end
			end
			PH_WAIT2: begin
				st_d.tick = t_inc;
				if (t_inc >= cfg.wait_len) begin
					st_d.sector = (st_q.sector >= LAST_SECTOR) ? 3'd0 : st_q.sector + 3'd1;
					st_d        = enter(st_d, PH_HOME1);
				end
			end
			default: begin
				st_d = enter(st_q, PH_HOME1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase    <= PH_HOME1;
			st_q.tick     <= '0;
			st_q.steps    <= '0;
			st_q.samples  <= '0;
			st_q.sector   <= '0;
			st_q.step_pin <= 1'b0;
			st_q.dir      <= 1'b1;
			st_q.en_n     <= 1'b1;
			st_q.stepping <= 1'b0;
		end else if (advance) begin
			st_q <= st_d;
		end
	end

	assign res.step_level     = st_d.step_pin;
	assign res.dir_level      = st_d.dir;
	assign res.enable_n       = st_d.en_n;
	assign res.phase          = st_d.phase;
	assign res.current_sector = st_d.sector;
	assign res.home_confirmed = confirmed;

endmodule
